// ===== rtl/tnpd_pkg.sv =====
// Shared types and constants for the three-nearest pixel distance block.
// No dependencies; used by every file under rtl but tnpd_pixel_mem.
package tnpd_pkg;

  localparam int MAX_ROWS_DEF = 256;
  localparam int MAX_COLS_DEF = 256;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // number of set pixels to collect
  localparam logic [1:0] NEAREST = 2'd3;

  // x / 3 == (x * RECIP3) >> 33 for any 32-bit x
  localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
  localparam int          RECIP3_SHR = 33;

  typedef enum logic [2:0] {
    W_IDLE,
    W_INIT,
    W_SIDE,
    W_SCAN,
    W_DRAIN,
    W_DONE
  } walk_state_e;

  typedef struct packed {
    logic [7:0]       row;
    logic [7:0]       col;
    logic [CFG_W-1:0] nr;
    logic [CFG_W-1:0] nc;
  } query_t;

  typedef struct packed {
    logic             found;
    logic [SUM_W-1:0] sum;
  } result_t;

endpackage

// ===== rtl/tnpd_pixel_mem.sv =====
// One-bit-wide pixel map: one write port, one read port, registered read.
// Depends on nothing.
module tnpd_pixel_mem #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [0:(1<<AW)-1];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/tnpd_ring_walk.sv =====
// Ring sequencer: walks Chebyshev rings side by side, clipped to the image,
// one pixel-map read per scan cycle, and sums the radii of the first three hits.
// Depends on tnpd_pkg.
module tnpd_ring_walk #(
  parameter int MAX_ROWS = tnpd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tnpd_pkg::MAX_COLS_DEF,
  parameter int RIW      = $clog2(MAX_ROWS),
  parameter int CIW      = $clog2(MAX_COLS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  tnpd_pkg::query_t  query_i,
  output logic              busy_o,
  output logic              rd_en_o,
  output logic [RIW+CIW-1:0] rd_addr_o,
  input  logic              rd_data_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output tnpd_pkg::result_t res_o
);

  localparam int MAXD = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int RADW = $clog2((MAXD > 256) ? MAXD : 256);
  localparam int SW   = RADW + 2;

  tnpd_pkg::walk_state_e state_q, state_d;
  tnpd_pkg::query_t      q_q;

  logic [RADW-1:0]           rmax_q, rmax_d;
  logic [RADW-1:0]           rad_q, rad_d;
  logic [1:0]                side_q, side_d;
  logic                      along_q, along_d;
  logic signed [SW-1:0]      fix_q, fix_d, pos_q, pos_d, end_q, end_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [tnpd_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                      rd_valid_q;
  logic [RADW-1:0]           rd_rad_q;

  logic signed [SW-1:0] rs, cs, nrm1, ncm1, rsig;
  logic signed [SW-1:0] rmax_s;
  logic signed [SW-1:0] s_fix, s_fix_lim, s_lo_raw, s_hi_raw, s_hi_lim, s_lo, s_hi;
  logic                 side_ok, empty, last_ring, done;
  tnpd_pkg::walk_state_e adv_state;

  assign rs   = $signed({{(SW-8){1'b0}}, q_q.row});
  assign cs   = $signed({{(SW-8){1'b0}}, q_q.col});
  assign nrm1 = $signed({{(SW-tnpd_pkg::CFG_W){1'b0}}, q_q.nr}) - SW'(1);
  assign ncm1 = $signed({{(SW-tnpd_pkg::CFG_W){1'b0}}, q_q.nc}) - SW'(1);
  assign rsig = $signed({2'b00, rad_q});

  // farthest image edge from the point, in Chebyshev distance
  always_comb begin
    rmax_s = rs;
    if ((nrm1 - rs) > rmax_s) rmax_s = nrm1 - rs;
    if (cs > rmax_s)          rmax_s = cs;
    if ((ncm1 - cs) > rmax_s) rmax_s = ncm1 - cs;
  end

  assign empty = (q_q.nr == '0) || (q_q.nc == '0) || (rmax_s[RADW-1:0] == '0);

  // top and bottom rows span the full width; left and right columns skip corners
  always_comb begin
    case (side_q)
      2'd0: begin
        s_fix = rs - rsig; s_fix_lim = nrm1;
        s_lo_raw = cs - rsig; s_hi_raw = cs + rsig; s_hi_lim = ncm1;
      end
      2'd1: begin
        s_fix = rs + rsig; s_fix_lim = nrm1;
        s_lo_raw = cs - rsig; s_hi_raw = cs + rsig; s_hi_lim = ncm1;
      end
      2'd2: begin
        s_fix = cs - rsig; s_fix_lim = ncm1;
        s_lo_raw = rs - rsig + SW'(1); s_hi_raw = rs + rsig - SW'(1); s_hi_lim = nrm1;
      end
      default: begin
        s_fix = cs + rsig; s_fix_lim = ncm1;
        s_lo_raw = rs - rsig + SW'(1); s_hi_raw = rs + rsig - SW'(1); s_hi_lim = nrm1;
      end
    endcase
    s_lo    = (s_lo_raw < 0) ? '0 : s_lo_raw;
    s_hi    = (s_hi_raw > s_hi_lim) ? s_hi_lim : s_hi_raw;
    side_ok = (s_fix >= 0) && (s_fix <= s_fix_lim) && (s_lo <= s_hi);
  end

  assign done      = (cnt_q == tnpd_pkg::NEAREST);
  assign last_ring = (side_q == 2'd3) && (rad_q == rmax_q);
  assign adv_state = last_ring ? tnpd_pkg::W_DRAIN : tnpd_pkg::W_SIDE;

  always_comb begin : next_state
    state_d = state_q;
    unique case (state_q)
      tnpd_pkg::W_IDLE:  if (start_i) state_d = tnpd_pkg::W_INIT;
      tnpd_pkg::W_INIT:  state_d = empty ? tnpd_pkg::W_DRAIN : tnpd_pkg::W_SIDE;
      tnpd_pkg::W_SIDE: begin
        if (done)         state_d = tnpd_pkg::W_DRAIN;
        else if (side_ok) state_d = tnpd_pkg::W_SCAN;
        else              state_d = adv_state;
      end
      tnpd_pkg::W_SCAN: begin
        if (done)                state_d = tnpd_pkg::W_DRAIN;
        else if (pos_q == end_q) state_d = adv_state;
      end
      tnpd_pkg::W_DRAIN: state_d = tnpd_pkg::W_DONE;
      tnpd_pkg::W_DONE:  if (res_ready_i) state_d = tnpd_pkg::W_IDLE;
      default:           state_d = tnpd_pkg::W_IDLE;
    endcase
  end

  always_comb begin : datapath
    rmax_d  = rmax_q;
    rad_d   = rad_q;
    side_d  = side_q;
    along_d = along_q;
    fix_d   = fix_q;
    pos_d   = pos_q;
    end_d   = end_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;

    // hits land in the cycle after the read; all hits of a ring share its radius
    if (rd_valid_q && rd_data_i && !done) begin
      cnt_d = cnt_q + 2'd1;
      sum_d = sum_q + tnpd_pkg::SUM_W'(rd_rad_q);
    end

    case (state_q)
      tnpd_pkg::W_INIT: begin
        rmax_d = rmax_s[RADW-1:0];
        rad_d  = RADW'(1);
        side_d = 2'd0;
        cnt_d  = '0;
        sum_d  = '0;
      end
      tnpd_pkg::W_SIDE: begin
        if (side_ok) begin
          fix_d   = s_fix;
          pos_d   = s_lo;
          end_d   = s_hi;
          along_d = ~side_q[1];
        end else if (side_q == 2'd3) begin
          if (!last_ring) begin
            rad_d  = rad_q + RADW'(1);
            side_d = 2'd0;
          end
        end else begin
          side_d = side_q + 2'd1;
        end
      end
      tnpd_pkg::W_SCAN: begin
        if (pos_q != end_q) begin
          pos_d = pos_q + SW'(1);
        end else if (side_q == 2'd3) begin
          if (!last_ring) begin
            rad_d  = rad_q + RADW'(1);
            side_d = 2'd0;
          end
        end else begin
          side_d = side_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin : outputs
    busy_o      = (state_q != tnpd_pkg::W_IDLE);
    rd_en_o     = (state_q == tnpd_pkg::W_SCAN) && !done;
    res_valid_o = (state_q == tnpd_pkg::W_DONE);
    res_o.found = done;
    res_o.sum   = done ? sum_q : '0;
  end

  logic signed [SW-1:0] rd_row, rd_col;
  assign rd_row    = along_q ? fix_q : pos_q;
  assign rd_col    = along_q ? pos_q : fix_q;
  assign rd_addr_o = {rd_row[RIW-1:0], rd_col[CIW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tnpd_pkg::W_IDLE;
      cnt_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_valid_q <= rd_en_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tnpd_pkg::W_IDLE && start_i) begin
      q_q <= query_i;
    end
    rmax_q   <= rmax_d;
    rad_q    <= rad_d;
    side_q   <= side_d;
    along_q  <= along_d;
    fix_q    <= fix_d;
    pos_q    <= pos_d;
    end_q    <= end_d;
    sum_q    <= sum_d;
    rd_rad_q <= rad_q;
  end

endmodule

// ===== rtl/three_nearest_pixel_distance_core.sv =====
// Three-nearest pixel distance search over a one-bit pixel map.
// Input channel (in_*): operation 0 writes one pixel (stored as value != 0),
//   operation 1 queries the point (row, col).
// Output channel (out_*): one item per query: found, sum of the three smallest
//   nonzero Chebyshev radii of set pixels, and that sum / 3 in Q8.8, rounded.
// Config port: cfg_we_i with cfg_index_i 0 = row_count, 1 = col_count.
// A write does not stall the input; the next item may follow at once.
// A query: a set-up state, then the walk: per ring, a side state for each of
//   the four sides, then a scan of its in-image pixels, one pixel-map read per
//   cycle while scanning. The walk ends after the farthest ring, or once the
//   third set pixel's hit is counted; an empty or one-pixel image skips it.
//   Then a drain state lets the last read land and a done state offers the
//   result; the input stalls until it is taken and the walk is idle again.
// The result sits in an output register; a stalled result holds and the
//   block still accepts writes, while a finished query waits for the slot.
// Reset sets both counts to 256 and empties the output; the pixel map has
//   no reset and must be written before it is queried. There is no
//   clearing pass.
// Depends on tnpd_pkg, tnpd_pixel_mem and tnpd_ring_walk.
module three_nearest_pixel_distance_core #(
  parameter int MAX_ROWS = tnpd_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tnpd_pkg::MAX_COLS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tnpd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tnpd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_operation_i,
  input  logic [7:0]                     in_row_i,
  input  logic [7:0]                     in_col_i,
  input  logic [7:0]                     in_pixel_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_found_o,
  output logic [9:0]                     out_radius_sum_o,
  output logic [15:0]                    out_mean_q8_o
);

  localparam int RIW = $clog2(MAX_ROWS);
  localparam int CIW = $clog2(MAX_COLS);
  localparam int AW  = RIW + CIW;

  logic [tnpd_pkg::CFG_W-1:0] row_count_q, col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= 9'd256;
      col_count_q <= 9'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tnpd_pkg::REG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        tnpd_pkg::REG_COL_COUNT: col_count_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic in_acc, walk_busy, mem_we, start;
  logic rd_en, rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  tnpd_pkg::query_t  query;
  tnpd_pkg::result_t res;
  logic res_valid, res_ready;

  assign in_stall_o = walk_busy;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign start      = in_acc && (in_operation_i == tnpd_pkg::OP_QUERY);
  assign mem_we     = in_acc && (in_operation_i == tnpd_pkg::OP_WRITE)
                      && (32'(in_row_i) < MAX_ROWS) && (32'(in_col_i) < MAX_COLS);
  assign wr_addr    = {RIW'(in_row_i), CIW'(in_col_i)};

  always_comb begin
    query.row = in_row_i;
    query.col = in_col_i;
    query.nr  = (32'(row_count_q) > MAX_ROWS) ? tnpd_pkg::CFG_W'(MAX_ROWS) : row_count_q;
    query.nc  = (32'(col_count_q) > MAX_COLS) ? tnpd_pkg::CFG_W'(MAX_COLS) : col_count_q;
  end

  tnpd_pixel_mem #(
    .AW (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (|in_pixel_value_i),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  tnpd_ring_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .RIW      (RIW),
    .CIW      (CIW)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .query_i     (query),
    .busy_o      (walk_busy),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // mean = (sum * 256 + 1) / 3 by reciprocal multiply
  logic [31:0] mean_num;
  logic [63:0] mean_prod;
  assign mean_num  = 32'({res.sum, 8'h00}) + 32'd1;
  assign mean_prod = 64'(mean_num) * 64'(tnpd_pkg::RECIP3);

  logic        out_valid_q, out_valid_d;
  logic        found_q;
  logic [9:0]  rsum_q;
  logic [15:0] mean_q;

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready)      out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      found_q <= res.found;
      rsum_q  <= res.sum[9:0];
      mean_q  <= res.found ? mean_prod[tnpd_pkg::RECIP3_SHR+15:tnpd_pkg::RECIP3_SHR] : 16'd0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_found_o      = found_q;
  assign out_radius_sum_o = rsum_q;
  assign out_mean_q8_o    = mean_q;

endmodule

// ===== rtl/tnpd_checker.sv =====
// Port-level checks for three_nearest_pixel_distance_core, bound to the top.
// Depends on tnpd_pkg and the top level.
module tnpd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        in_operation_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        out_found_o,
  input logic [9:0]  out_radius_sum_o,
  input logic [15:0] out_mean_q8_o
);

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_radius_sum_o == 10'd0 && out_mean_q8_o == 16'd0)
    else $error("not-found result carries nonzero payload");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_operation_i == tnpd_pkg::OP_QUERY) |=> in_stall_o)
    else $error("query item accepted but block not busy");

  a_write_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_operation_i == tnpd_pkg::OP_WRITE) |=> !in_stall_o)
    else $error("write item left the block busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_found_o)
      && $stable(out_radius_sum_o) && $stable(out_mean_q8_o))
    else $error("stalled result item changed");

endmodule

bind three_nearest_pixel_distance_core tnpd_checker u_tnpd_checker (.*);
